FILE: design/dda_pkg.sv
// Shared types, constants and calendar functions for the date day arithmetic core.
// Fixed 365-day year, no leap years. No dependencies.
package dda_pkg;

    localparam int YEAR_W   = 12;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int COUNT_W  = 16;
    localparam int SERIAL_W = 21;
    localparam int DIFF_W   = 22;
    localparam int DOY_W    = 9;
    localparam int CMD_W    = 2;

    localparam int YEAR_DAYS  = 365;
    localparam int YEAR_MAX   = 4095;
    localparam int SERIAL_LO  = YEAR_DAYS;
    localparam int SERIAL_HI  = YEAR_MAX * YEAR_DAYS + (YEAR_DAYS - 1);
    localparam int DDA_QUEUE_DEPTH = 2;

    localparam logic [CMD_W-1:0] CMD_ADD  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SUB  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DIFF = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]    cmd;
        logic [SERIAL_W-1:0] serial;
        logic [SERIAL_W-1:0] ref_serial;
        logic [COUNT_W-1:0]  count;
        logic [YEAR_W-1:0]   year;
        logic [MONTH_W-1:0]  month;
        logic [DAY_W-1:0]    day;
    } dda_item_t;

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] len;
        case (m)
            4'd2:    len = 5'd28;
            4'd4:    len = 5'd30;
            4'd6:    len = 5'd30;
            4'd9:    len = 5'd30;
            4'd11:   len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

    function automatic logic [DOY_W-1:0] month_start(input logic [MONTH_W-1:0] m);
        logic [DOY_W-1:0] st;
        case (m)
            4'd2:    st = 9'd31;
            4'd3:    st = 9'd59;
            4'd4:    st = 9'd90;
            4'd5:    st = 9'd120;
            4'd6:    st = 9'd151;
            4'd7:    st = 9'd181;
            4'd8:    st = 9'd212;
            4'd9:    st = 9'd243;
            4'd10:   st = 9'd273;
            4'd11:   st = 9'd304;
            4'd12:   st = 9'd334;
            default: st = 9'd0;
        endcase
        return st;
    endfunction

    function automatic logic [MONTH_W-1:0] fix_month(input logic [MONTH_W-1:0] m);
        logic [MONTH_W-1:0] r;
        if (m == 4'd0)
            r = 4'd1;
        else if (m > 4'd12)
            r = 4'd12;
        else
            r = m;
        return r;
    endfunction

    function automatic logic [DAY_W-1:0] fix_day(input logic [DAY_W-1:0] d,
                                                  input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] len;
        logic [DAY_W-1:0] r;
        len = month_len(m);
        if (d == 5'd0)
            r = 5'd1;
        else if (d > len)
            r = len;
        else
            r = d;
        return r;
    endfunction

    function automatic logic [SERIAL_W-1:0] serial_of(input logic [YEAR_W-1:0] y,
                                                       input logic [MONTH_W-1:0] m,
                                                       input logic [DAY_W-1:0] d);
        logic [SERIAL_W-1:0] p;
        p = SERIAL_W'(y) * SERIAL_W'(YEAR_DAYS);
        return p + SERIAL_W'(month_start(m)) + SERIAL_W'(d) - SERIAL_W'(1);
    endfunction

    // Month of a day-of-year: count month starts at or below it.
    function automatic logic [MONTH_W-1:0] month_of(input logic [DOY_W-1:0] doy);
        logic [MONTH_W-1:0] cnt;
        cnt = 4'd1;
        for (int k = 2; k <= 12; k++) begin
            if (month_start(MONTH_W'(k)) <= doy)
                cnt = cnt + 4'd1;
        end
        return cnt;
    endfunction

endpackage

FILE: design/dda_front.sv
// Front end: repairs the operand and reference dates and forms their serial day numbers.
// Depends on dda_pkg.
module dda_front
    import dda_pkg::*;
(
    input  logic [CMD_W-1:0]   cmd,
    input  logic [YEAR_W-1:0]  year_in,
    input  logic [MONTH_W-1:0] month_in,
    input  logic [DAY_W-1:0]   day_in,
    input  logic [COUNT_W-1:0] day_count,
    input  logic [YEAR_W-1:0]  ref_year,
    input  logic [MONTH_W-1:0] ref_month,
    input  logic [DAY_W-1:0]   ref_day,
    output dda_item_t          item
);

    logic [MONTH_W-1:0] op_month;
    logic [DAY_W-1:0]   op_day;
    logic [MONTH_W-1:0] rf_month;
    logic [DAY_W-1:0]   rf_day;

    always_comb
    begin
        op_month = fix_month(month_in);
        op_day   = fix_day(day_in, op_month);
        rf_month = fix_month(ref_month);
        rf_day   = fix_day(ref_day, rf_month);

        item.cmd        = cmd;
        item.serial     = serial_of(year_in, op_month, op_day);
        // reference serial only matters for difference
        item.ref_serial = (cmd == CMD_DIFF) ? serial_of(ref_year, rf_month, rf_day)
                                            : '0;
        item.count      = day_count;
        item.year       = year_in;
        item.month      = op_month;
        item.day        = op_day;
    end

endmodule

FILE: design/dda_queue.sv
// Short request queue between the front end and the back end.
// Depends on dda_pkg.
module dda_queue
    import dda_pkg::*;
#(
    parameter int DEPTH = DDA_QUEUE_DEPTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  dda_item_t push_item,
    input  logic      pop,
    output dda_item_t head_item,
    output logic      empty,
    output logic      full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    dda_item_t          slots_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign empty     = (count_reg == '0);
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign head_item = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slots_reg[wr_ptr_reg] <= push_item;
    end

endmodule

FILE: design/dda_back.sv
// Back end: executes one queued request: add/subtract with saturation, split into year and
// day of year by a reciprocal multiply, month lookup, or serial difference. Depends on dda_pkg.
module dda_back
    import dda_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  dda_item_t           head_item,
    input  logic                empty,
    output logic                pop,
    output logic                done,
    output logic [YEAR_W-1:0]   year_out,
    output logic [MONTH_W-1:0]  month_out,
    output logic [DAY_W-1:0]    day_out,
    output logic [DIFF_W-1:0]   day_difference,
    output logic                range_flag
);

    localparam int QUOT_W      = YEAR_W;
    localparam int RECIP_W     = 22;
    localparam int RECIP_SHIFT = 30;
    localparam int PROD_W      = SERIAL_W + RECIP_W;
    // ceil(2^30 / 365): exact quotient for every serial up to SERIAL_HI
    localparam logic [RECIP_W-1:0] RECIP_365 = 22'd2941759;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_CALC = 5'b00010,
        ST_DIV  = 5'b00100,
        ST_REM  = 5'b01000,
        ST_FIN  = 5'b10000
    } back_state_t;

    back_state_t          state_reg, state_next;
    dda_item_t            item_reg, item_next;
    logic [SERIAL_W-1:0]  work_reg, work_next;
    logic [QUOT_W-1:0]    quot_reg, quot_next;
    logic [DOY_W-1:0]     doy_reg, doy_next;
    logic                 flag_reg, flag_next;
    logic                 done_reg, done_next;
    logic [YEAR_W-1:0]    year_reg, year_next;
    logic [MONTH_W-1:0]   month_reg, month_next;
    logic [DAY_W-1:0]     day_reg, day_next;
    logic [DIFF_W-1:0]    diff_reg, diff_next;
    logic                 range_reg, range_next;

    logic [DIFF_W-1:0]    t_sum;
    logic                 t_flag;
    logic [PROD_W-1:0]    prod;
    logic [SERIAL_W-1:0]  rem_wide;
    logic [MONTH_W-1:0]   fin_month;

    assign pop            = (state_reg == ST_IDLE) && !empty;
    assign done           = done_reg;
    assign year_out       = year_reg;
    assign month_out      = month_reg;
    assign day_out        = day_reg;
    assign day_difference = diff_reg;
    assign range_flag     = range_reg;

    always_comb
    begin
        state_next = state_reg;
        item_next  = item_reg;
        work_next  = work_reg;
        quot_next  = quot_reg;
        doy_next   = doy_reg;
        flag_next  = flag_reg;
        done_next  = 1'b0;
        year_next  = year_reg;
        month_next = month_reg;
        day_next   = day_reg;
        diff_next  = diff_reg;
        range_next = range_reg;

        // target serial for add and subtract, saturated to the legal range
        t_flag = 1'b0;
        if (item_reg.cmd == CMD_ADD)
            t_sum = DIFF_W'(item_reg.serial) + DIFF_W'(item_reg.count);
        else if (item_reg.serial < SERIAL_W'(item_reg.count))
        begin
            t_sum  = '0;
            t_flag = 1'b1;
        end
        else
            t_sum = DIFF_W'(item_reg.serial) - DIFF_W'(item_reg.count);
        if (t_sum < DIFF_W'(SERIAL_LO))
        begin
            t_sum  = DIFF_W'(SERIAL_LO);
            t_flag = 1'b1;
        end
        if (t_sum > DIFF_W'(SERIAL_HI))
        begin
            t_sum  = DIFF_W'(SERIAL_HI);
            t_flag = 1'b1;
        end

        // year by reciprocal multiply, day of year from the registered quotient
        prod      = PROD_W'(work_reg) * PROD_W'(RECIP_365);
        rem_wide  = work_reg - SERIAL_W'(quot_reg) * SERIAL_W'(YEAR_DAYS);
        fin_month = month_of(doy_reg);

        case (state_reg)
            ST_IDLE:
            begin
                if (!empty)
                begin
                    item_next  = head_item;
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                if (item_reg.cmd == CMD_ADD || item_reg.cmd == CMD_SUB)
                begin
                    work_next  = t_sum[SERIAL_W-1:0];
                    flag_next  = t_flag;
                    state_next = ST_DIV;
                end
                else
                begin
                    year_next  = item_reg.year;
                    month_next = item_reg.month;
                    day_next   = item_reg.day;
                    diff_next  = (item_reg.cmd == CMD_DIFF)
                               ? DIFF_W'(item_reg.serial) - DIFF_W'(item_reg.ref_serial)
                               : '0;
                    range_next = 1'b0;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_DIV:
            begin
                quot_next  = prod[RECIP_SHIFT +: QUOT_W];
                state_next = ST_REM;
            end
            ST_REM:
            begin
                doy_next   = rem_wide[DOY_W-1:0];
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                year_next  = quot_reg;
                month_next = fin_month;
                day_next   = DAY_W'(doy_reg - month_start(fin_month) + DOY_W'(1));
                diff_next  = '0;
                range_next = flag_reg;
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg  <= item_next;
        work_reg  <= work_next;
        quot_reg  <= quot_next;
        doy_reg   <= doy_next;
        flag_reg  <= flag_next;
        year_reg  <= year_next;
        month_reg <= month_next;
        day_reg   <= day_next;
        diff_reg  <= diff_next;
        range_reg <= range_next;
    end

endmodule

FILE: design/date_day_arithmetic_core.sv
// Date day arithmetic core, 365-day year. A request is taken whenever the queue has room.
// Add/subtract: the request passes from the queue through the back-end states CALC, DIV, REM
// and FIN to the result strobe (reciprocal multiply for the year, remainder, month lookup).
// Difference and unused command: through CALC only. done is a one-cycle strobe.
// Asynchronous active-low reset empties the queue and idles the back end.
module date_day_arithmetic_core
    import dda_pkg::*;
#(
    parameter int QUEUE_DEPTH = DDA_QUEUE_DEPTH
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [CMD_W-1:0]     cmd,
    input  logic [YEAR_W-1:0]    year_in,
    input  logic [MONTH_W-1:0]   month_in,
    input  logic [DAY_W-1:0]     day_in,
    input  logic [COUNT_W-1:0]   day_count,
    input  logic [YEAR_W-1:0]    ref_year,
    input  logic [MONTH_W-1:0]   ref_month,
    input  logic [DAY_W-1:0]     ref_day,
    output logic                 done,
    output logic [YEAR_W-1:0]    year_out,
    output logic [MONTH_W-1:0]   month_out,
    output logic [DAY_W-1:0]     day_out,
    output logic [DIFF_W-1:0]    day_difference,
    output logic                 range_flag
);

    dda_item_t front_item;
    dda_item_t head_item;
    logic      q_push;
    logic      q_pop;
    logic      q_empty;
    logic      q_full;

    assign busy   = q_full;
    assign q_push = start && !q_full;

    dda_front u_front
    (
        .cmd       (cmd),
        .year_in   (year_in),
        .month_in  (month_in),
        .day_in    (day_in),
        .day_count (day_count),
        .ref_year  (ref_year),
        .ref_month (ref_month),
        .ref_day   (ref_day),
        .item      (front_item)
    );

    dda_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (front_item),
        .pop       (q_pop),
        .head_item (head_item),
        .empty     (q_empty),
        .full      (q_full)
    );

    dda_back u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .head_item      (head_item),
        .empty          (q_empty),
        .pop            (q_pop),
        .done           (done),
        .year_out       (year_out),
        .month_out      (month_out),
        .day_out        (day_out),
        .day_difference (day_difference),
        .range_flag     (range_flag)
    );

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for two cycles");

    a_sat_year: assert property (@(posedge clk) disable iff (!rst_n)
        (done && range_flag) |-> (year_out == YEAR_W'(1) || year_out == YEAR_W'(YEAR_MAX)))
        else $error("saturated result not at year limit");

    a_diff_noflag: assert property (@(posedge clk) disable iff (!rst_n)
        (done && day_difference != '0) |-> !range_flag)
        else $error("difference result carries range flag");

    a_date_legal: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (month_out != '0 && month_out <= MONTH_W'(12) && day_out != '0))
        else $error("result date out of range");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("back end popped an empty queue");

endmodule

FILE: bench/date_day_arithmetic_core_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for date_day_arithmetic_core: add, subtract, difference, unused command.
// Compares every result strobe against a calendar predictor. Depends on dda_pkg.

module date_day_arithmetic_core_tb;
    import dda_pkg::*;

    localparam int RANDOM_REQUESTS = 1000;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int DRAIN_CYCLES    = 40;

    typedef struct {
        logic [CMD_W-1:0]   cmd;
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [COUNT_W-1:0] count;
        logic [YEAR_W-1:0]  ref_y;
        logic [MONTH_W-1:0] ref_m;
        logic [DAY_W-1:0]   ref_d;
    } date_request_t;

    typedef struct {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [DIFF_W-1:0]  diff;
        logic               flag;
    } date_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [CMD_W-1:0]     cmd = CMD_ADD;
    logic [YEAR_W-1:0]    year_in = '0;
    logic [MONTH_W-1:0]   month_in = '0;
    logic [DAY_W-1:0]     day_in = '0;
    logic [COUNT_W-1:0]   day_count = '0;
    logic [YEAR_W-1:0]    ref_year = '0;
    logic [MONTH_W-1:0]   ref_month = '0;
    logic [DAY_W-1:0]     ref_day = '0;
    logic                 done;
    logic [YEAR_W-1:0]    year_out;
    logic [MONTH_W-1:0]   month_out;
    logic [DAY_W-1:0]     day_out;
    logic [DIFF_W-1:0]    day_difference;
    logic                 range_flag;

    int days_in_month [13]     = '{0, 31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    int days_before_month [13] = '{0, 0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

    date_request_t pending_requests[$];
    date_result_t  expected_dates[$];
    date_request_t on_port;

    int requests_total    = 0;
    int requests_accepted = 0;
    int results_checked   = 0;
    int saturated_results = 0;
    int mismatches        = 0;
    int cycles            = 0;
    int cmd_seen [4]      = '{0, 0, 0, 0};
    logic steady_stretch;

    date_day_arithmetic_core u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .cmd            (cmd),
        .year_in        (year_in),
        .month_in       (month_in),
        .day_in         (day_in),
        .day_count      (day_count),
        .ref_year       (ref_year),
        .ref_month      (ref_month),
        .ref_day        (ref_day),
        .done           (done),
        .year_out       (year_out),
        .month_out      (month_out),
        .day_out        (day_out),
        .day_difference (day_difference),
        .range_flag     (range_flag)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    function automatic int legal_month(input logic [MONTH_W-1:0] m);
        if (m == 0)
            return 1;
        if (m > 12)
            return 12;
        return int'(m);
    endfunction

    function automatic int legal_day(input logic [DAY_W-1:0] d, input int m);
        if (d == 0)
            return 1;
        if (d > days_in_month[m])
            return days_in_month[m];
        return int'(d);
    endfunction

    function automatic int serial_number(input int y, input int m, input int d);
        return y * YEAR_DAYS + days_before_month[m] + d - 1;
    endfunction

    function automatic date_result_t predict_date_result(input date_request_t r);
        date_result_t res;
        int mon;
        int dy;
        int rmon;
        int here;
        int target;
        int doy;
        int k;
        int cnt;
        logic signed [31:0] delta;
        mon  = legal_month(r.month);
        dy   = legal_day(r.day, mon);
        rmon = legal_month(r.ref_m);
        cnt  = int'(r.count);
        here = serial_number(int'(r.year), mon, dy);
        res.year  = r.year;
        res.month = MONTH_W'(mon);
        res.day   = DAY_W'(dy);
        res.diff  = '0;
        res.flag  = 1'b0;
        if (r.cmd == CMD_ADD || r.cmd == CMD_SUB) begin
            if (r.cmd == CMD_ADD) begin
                target = here + cnt;
            end
            else if (here >= cnt) begin
                target = here - cnt;
            end
            else begin
                target   = 0;
                res.flag = 1'b1;
            end
            // clamp to 1-1-1 .. 4095-12-31
            if (target < SERIAL_LO) begin
                target   = SERIAL_LO;
                res.flag = 1'b1;
            end
            if (target > SERIAL_HI) begin
                target   = SERIAL_HI;
                res.flag = 1'b1;
            end
            doy = target % YEAR_DAYS;
            k   = 12;
            while (k > 1 && days_before_month[k] > doy)
                k--;
            res.year  = YEAR_W'(target / YEAR_DAYS);
            res.month = MONTH_W'(k);
            res.day   = DAY_W'(doy - days_before_month[k] + 1);
        end
        else if (r.cmd == CMD_DIFF) begin
            delta = here - serial_number(int'(r.ref_y), rmon, legal_day(r.ref_d, rmon));
            res.diff = delta[DIFF_W-1:0];
        end
        return res;
    endfunction

    function automatic date_request_t make_request(input logic [CMD_W-1:0] c,
                                                   input int y, input int m, input int d,
                                                   input int n, input int ry, input int rm,
                                                   input int rd);
        date_request_t r;
        r.cmd   = c;
        r.year  = YEAR_W'(y);
        r.month = MONTH_W'(m);
        r.day   = DAY_W'(d);
        r.count = COUNT_W'(n);
        r.ref_y = YEAR_W'(ry);
        r.ref_m = MONTH_W'(rm);
        r.ref_d = DAY_W'(rd);
        return r;
    endfunction

    // Mostly legal dates, biased toward both ends of the year range; some raw bit patterns.
    function automatic void random_date(output logic [YEAR_W-1:0] y,
                                        output logic [MONTH_W-1:0] m,
                                        output logic [DAY_W-1:0] d);
        int pick;
        pick = $urandom_range(99);
        if (pick < 15)
            y = YEAR_W'($urandom_range(200));
        else if (pick < 30)
            y = YEAR_W'($urandom_range(4095, 3900));
        else
            y = YEAR_W'($urandom_range(4095));
        if ($urandom_range(99) < 88)
            m = MONTH_W'($urandom_range(12, 1));
        else
            m = MONTH_W'($urandom_range(15));
        if ($urandom_range(99) < 88 && m >= 1 && m <= 12)
            d = DAY_W'($urandom_range(days_in_month[m], 1));
        else
            d = DAY_W'($urandom_range(31));
    endfunction

    function automatic date_request_t random_request();
        date_request_t r;
        int pick;
        pick = $urandom_range(99);
        if (pick < 40)
            r.cmd = CMD_ADD;
        else if (pick < 70)
            r.cmd = CMD_SUB;
        else if (pick < 95)
            r.cmd = CMD_DIFF;
        else
            r.cmd = CMD_NONE;
        random_date(r.year, r.month, r.day);
        random_date(r.ref_y, r.ref_m, r.ref_d);
        pick = $urandom_range(99);
        if (pick < 30)
            r.count = COUNT_W'($urandom_range(400));
        else if (pick < 45)
            r.count = $urandom_range(1) ? 16'hFFFF : 16'h0000;
        else
            r.count = COUNT_W'($urandom_range(65535));
        return r;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    // no idle cycles on the sending side for a stretch in the middle of the run
    assign steady_stretch = (requests_accepted >= 400 && requests_accepted < 560);

    always @(posedge clk)
    begin : driver
        if (rst_n) begin
            if (start && !busy) begin
                expected_dates.push_back(predict_date_result(on_port));
                cmd_seen[on_port.cmd]++;
                requests_accepted++;
            end
            // hold the request on the ports until it is taken
            if (!start || !busy) begin
                if (pending_requests.size() != 0 && (steady_stretch || $urandom_range(99) >= 37))
                begin
                    on_port = pending_requests.pop_front();
                    start     <= 1'b1;
                    cmd       <= on_port.cmd;
                    year_in   <= on_port.year;
                    month_in  <= on_port.month;
                    day_in    <= on_port.day;
                    day_count <= on_port.count;
                    ref_year  <= on_port.ref_y;
                    ref_month <= on_port.ref_m;
                    ref_day   <= on_port.ref_d;
                end
                else begin
                    start <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin : monitor
        date_result_t want;
        if (rst_n && done) begin
            if (expected_dates.size() == 0) begin
                $display("%0t ns: result with no request outstanding, year %0d month %0d day %0d",
                         $time, year_out, month_out, day_out);
                mismatches++;
            end
            else begin
                want = expected_dates.pop_front();
                check_field("year_out", int'(want.year), int'(year_out));
                check_field("month_out", int'(want.month), int'(month_out));
                check_field("day_out", int'(want.day), int'(day_out));
                check_field("day_difference", int'(want.diff), int'(day_difference));
                check_field("range_flag", int'(want.flag), int'(range_flag));
                results_checked++;
                if (range_flag)
                    saturated_results++;
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d requests outstanding", cycles,
                     expected_dates.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin : stimulus
        // edges of the calendar and of the count
        pending_requests.push_back(make_request(CMD_ADD, 1, 1, 1, 0, 1, 1, 1));
        pending_requests.push_back(make_request(CMD_ADD, 4095, 12, 31, 1, 1, 1, 1));
        pending_requests.push_back(make_request(CMD_ADD, 4095, 12, 31, 0, 1, 1, 1));
        pending_requests.push_back(make_request(CMD_SUB, 1, 1, 1, 1, 1, 1, 1));
        pending_requests.push_back(make_request(CMD_SUB, 1, 1, 1, 65535, 1, 1, 1));
        pending_requests.push_back(make_request(CMD_SUB, 1, 3, 1, 59, 1, 1, 1));
        // year zero, and a full count from year 2000
        pending_requests.push_back(make_request(CMD_ADD, 0, 1, 1, 0, 1, 1, 1));
        pending_requests.push_back(make_request(CMD_ADD, 0, 12, 31, 1, 1, 1, 1));
        pending_requests.push_back(make_request(CMD_SUB, 0, 1, 5, 0, 1, 1, 1));
        pending_requests.push_back(make_request(CMD_ADD, 2000, 1, 31, 65535, 1, 1, 1));
        // out-of-range months and days get corrected
        pending_requests.push_back(make_request(CMD_SUB, 4095, 15, 31, 65535, 1, 1, 1));
        pending_requests.push_back(make_request(CMD_ADD, 100, 0, 0, 31, 1, 1, 1));
        pending_requests.push_back(make_request(CMD_ADD, 100, 2, 31, 1, 1, 1, 1));
        pending_requests.push_back(make_request(CMD_ADD, 100, 13, 0, 400, 1, 1, 1));
        pending_requests.push_back(make_request(CMD_ADD, 100, 4, 31, 0, 1, 1, 1));
        // difference both ways, including zero and corrected reference, and an unused command
        pending_requests.push_back(make_request(CMD_DIFF, 4095, 12, 31, 0, 0, 0, 0));
        pending_requests.push_back(make_request(CMD_DIFF, 0, 1, 1, 65535, 4095, 12, 31));
        pending_requests.push_back(make_request(CMD_DIFF, 1500, 7, 4, 0, 1500, 7, 4));
        pending_requests.push_back(make_request(CMD_DIFF, 1000, 6, 15, 9, 2000, 15, 31));
        pending_requests.push_back(make_request(CMD_DIFF, 1000, 6, 15, 0, 999, 7, 20));
        pending_requests.push_back(make_request(CMD_NONE, 77, 14, 0, 65535, 5, 5, 5));
        // month and year boundaries
        pending_requests.push_back(make_request(CMD_SUB, 2024, 1, 1, 1, 1, 1, 1));
        pending_requests.push_back(make_request(CMD_ADD, 1999, 12, 31, 1, 1, 1, 1));
        pending_requests.push_back(make_request(CMD_ADD, 3000, 2, 28, 1, 1, 1, 1));
        pending_requests.push_back(make_request(CMD_SUB, 3000, 3, 1, 1, 1, 1, 1));
        for (int i = 0; i < RANDOM_REQUESTS; i++)
            pending_requests.push_back(random_request());
        requests_total = pending_requests.size();

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (requests_accepted != requests_total)
            @(negedge clk);
        while (expected_dates.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Ran %0d requests: %0d add, %0d subtract, %0d difference, %0d unused command",
                 requests_accepted, cmd_seen[CMD_ADD], cmd_seen[CMD_SUB], cmd_seen[CMD_DIFF],
                 cmd_seen[CMD_NONE]);
        $display("Checked %0d results, %0d saturated, %0d mismatches", results_checked,
                 saturated_results, mismatches);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
